### hw/rtl/tsee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsee_pkg
// Shared constants, types and helpers of the text screen edit engine.
// ----------------------------------------------------------------------------
package tsee_pkg;

	localparam int MAX_COLS  = 128;
	localparam int MAX_LINES = 64;
	localparam int CELL_BITS = 32;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int LINE_W = $clog2(MAX_LINES);
	localparam int ADDR_W = COL_W + LINE_W;
	localparam int CCNT_W = COL_W + 1;
	localparam int LCNT_W = LINE_W + 1;

	typedef logic [3:0] op_t;
	localparam op_t OP_WRITE = 4'd0;
	localparam op_t OP_READ  = 4'd1;
	localparam op_t OP_DCH   = 4'd2;
	localparam op_t OP_ICH   = 4'd3;
	localparam op_t OP_DL    = 4'd4;
	localparam op_t OP_IL    = 4'd5;
	localparam op_t OP_ECH   = 4'd6;
	localparam op_t OP_EL    = 4'd7;
	localparam op_t OP_ED    = 4'd8;
	localparam op_t OP_SD    = 4'd9;
	localparam op_t OP_SU    = 4'd10;

	typedef logic [1:0] emode_t;
	localparam emode_t ERASE_TO_END   = 2'd0;
	localparam emode_t ERASE_TO_START = 2'd1;
	localparam emode_t ERASE_ALL      = 2'd2;
	localparam emode_t ERASE_NONE     = 2'd3;

	typedef logic [1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_WIDTH  = 2'd0;
	localparam cfg_idx_t CFG_HEIGHT = 2'd1;
	localparam cfg_idx_t CFG_RING   = 2'd2;

	typedef struct packed {
		logic [CCNT_W-1:0] width;
		logic [LCNT_W-1:0] height;
		logic [LCNT_W-1:0] ring;
	} geom_t;

	typedef struct packed {
		op_t         op;
		logic [5:0]  row;
		logic [7:0]  col;
		logic [7:0]  cnt;
		emode_t      mode;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic                 we;
		logic [ADDR_W-1:0]    waddr;
		logic [CELL_BITS-1:0] wdata;
		logic                 re;
		logic [ADDR_W-1:0]    raddr;
	} mem_req_t;

	// logical row to physical line; origin < ring and row < ring
	function automatic logic [LINE_W-1:0] phys_line(input logic [LINE_W-1:0] origin,
			input logic [LINE_W-1:0] row, input logic [LCNT_W-1:0] ring);
		logic [LCNT_W-1:0] s;
		s = {1'b0, origin} + {1'b0, row};
		if (s >= ring) begin
			s = s - ring;
		end
		return s[LINE_W-1:0];
	endfunction

endpackage

### hw/rtl/tsee_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsee_store
// Cell store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsee_store (
	input  logic                          clk,
	input  tsee_pkg::mem_req_t            req,
	output logic [tsee_pkg::CELL_BITS-1:0] rdata
);
	import tsee_pkg::*;

	logic [CELL_BITS-1:0] mem [MAX_LINES*MAX_COLS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rdata <= mem[req.raddr];
		end
	end

endmodule

### hw/rtl/tsee_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsee_seq
// Command sequencer: plans each edit as a copy walk and up to two clear
// walks over the cell store, one cell access per cycle.
// ----------------------------------------------------------------------------
module tsee_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tsee_pkg::geom_t                geom,
	input  logic                           cmd_valid,
	output logic                           cmd_ready,
	input  tsee_pkg::cmd_t                 cmd,
	output logic                           res_valid,
	input  logic                           res_ready,
	output logic [tsee_pkg::CELL_BITS-1:0] res_value,
	output tsee_pkg::mem_req_t             mem_req,
	input  logic [tsee_pkg::CELL_BITS-1:0] rdata
);
	import tsee_pkg::*;

	typedef enum logic [3:0] {
		ST_INIT, ST_IDLE, ST_REDUCE, ST_LOAD, ST_SAT, ST_PLAN,
		ST_RWAIT, ST_COPY, ST_CLR, ST_DONE
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [LINE_W-1:0]    origin_q;
	logic [ADDR_W-1:0]    init_q;
	logic [COL_W-1:0]     x_q;
	logic [LINE_W-1:0]    y_q;
	logic [7:0]           n0_q;
	logic [7:0]           n_q;
	logic                 in_page_q;
	logic [CELL_BITS-1:0] res_q;

	logic [LCNT_W-1:0] cp_rows_q;
	logic [CCNT_W-1:0] cp_ncols_q, cp_left_q;
	logic [LINE_W-1:0] cp_drow_q, cp_srow_q;
	logic [COL_W-1:0]  cp_dcol_q, cp_scol_q, cp_dcol0_q, cp_scol0_q;
	logic              cp_down_q;
	logic              cp_s1;
	logic [ADDR_W-1:0] cp_waddr_s1;

	logic [LCNT_W-1:0] cl_row_q, cl_rend_q, c2_r0_q, c2_rend_q;
	logic [COL_W-1:0]  cl_col_q, cl_c0_q, c2_c0_q;
	logic [CCNT_W-1:0] cl_cend_q, c2_cend_q;
	logic              c2_valid_q;

	// plan outputs
	logic [LCNT_W-1:0] p_rows, p_r0, p_rend, p2_r0, p2_rend;
	logic [CCNT_W-1:0] p_ncols, p_cend, p2_cend;
	logic [LINE_W-1:0] p_drow, p_srow;
	logic [COL_W-1:0]  p_dcol, p_scol, p_c0, p2_c0;
	logic              p_down, p2_valid, p_org_we;
	logic [LINE_W-1:0] p_origin;

	logic [7:0] w8, h8, x8, y8, cell_cnt, row_cnt, avail, sd_t, su_t, r8;
	logic [LINE_W-1:0] y_line, d_line, s_line, c_line;
	logic              cl_active;

	assign w8 = 8'(geom.width);
	assign h8 = 8'(geom.height);
	assign x8 = 8'(x_q);
	assign y8 = 8'(y_q);
	assign r8 = 8'(geom.ring);
	assign cell_cnt = w8 - n_q - x8;
	assign row_cnt  = h8 - n_q - y8;

	assign y_line = phys_line(origin_q, y_q, geom.ring);
	assign d_line = phys_line(origin_q, cp_drow_q, geom.ring);
	assign s_line = phys_line(origin_q, cp_srow_q, geom.ring);
	assign c_line = phys_line(origin_q, cl_row_q[LINE_W-1:0], geom.ring);

	assign cl_active = (cl_row_q < cl_rend_q) && ({1'b0, cl_col_q} < cl_cend_q);

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);
	assign res_value = res_q;

	always_comb begin
		unique case (cmd_q.op)
			OP_DCH, OP_ICH, OP_ECH: avail = w8 - x8;
			OP_DL, OP_IL:           avail = h8 - y8;
			OP_SD, OP_SU:           avail = h8;
			default:                avail = n0_q;
		endcase
	end

	always_comb begin
		sd_t = 8'(origin_q) + r8 - n_q;
		if (sd_t >= r8) begin
			sd_t = sd_t - r8;
		end
		su_t = 8'(origin_q) + n_q;
		if (su_t >= r8) begin
			su_t = su_t - r8;
		end
	end

	// Turn the command into one copy walk and up to two clear rectangles.
	always_comb begin
		p_rows   = '0;
		p_ncols  = '0;
		p_drow   = y_q;
		p_srow   = y_q;
		p_dcol   = '0;
		p_scol   = '0;
		p_down   = 1'b0;
		p_r0     = '0;
		p_rend   = '0;
		p_c0     = '0;
		p_cend   = '0;
		p2_valid = 1'b0;
		p2_r0    = '0;
		p2_rend  = '0;
		p2_c0    = '0;
		p2_cend  = '0;
		p_org_we = 1'b0;
		p_origin = origin_q;
		unique case (cmd_q.op)
			OP_DCH: begin
				if (cell_cnt != 8'd0) begin
					p_rows  = LCNT_W'(1);
					p_ncols = CCNT_W'(cell_cnt);
					p_dcol  = x_q;
					p_scol  = COL_W'(x8 + n_q);
				end
				p_r0   = LCNT_W'(y8);
				p_rend = LCNT_W'(y8 + 8'd1);
				p_c0   = COL_W'(w8 - n_q);
				p_cend = geom.width;
			end
			OP_ICH: begin
				if (cell_cnt != 8'd0) begin
					p_rows  = LCNT_W'(1);
					p_ncols = CCNT_W'(cell_cnt);
					p_dcol  = COL_W'(w8 - 8'd1);
					p_scol  = COL_W'(w8 - 8'd1 - n_q);
					p_down  = 1'b1;
				end
				p_r0   = LCNT_W'(y8);
				p_rend = LCNT_W'(y8 + 8'd1);
				p_c0   = x_q;
				p_cend = CCNT_W'(x8 + n_q);
			end
			OP_DL: begin
				p_rows  = LCNT_W'(row_cnt);
				p_ncols = CCNT_W'(MAX_COLS);
				p_drow  = y_q;
				p_srow  = LINE_W'(y8 + n_q);
				p_r0    = LCNT_W'(h8 - n_q);
				p_rend  = geom.height;
				p_cend  = geom.width;
			end
			OP_IL: begin
				p_rows  = LCNT_W'(row_cnt);
				p_ncols = CCNT_W'(MAX_COLS);
				p_drow  = LINE_W'(h8 - 8'd1);
				p_srow  = LINE_W'(h8 - 8'd1 - n_q);
				p_dcol  = COL_W'(MAX_COLS - 1);
				p_scol  = COL_W'(MAX_COLS - 1);
				p_down  = 1'b1;
				p_r0    = LCNT_W'(y8);
				p_rend  = LCNT_W'(y8 + n_q);
				p_cend  = geom.width;
			end
			OP_ECH: begin
				p_r0   = LCNT_W'(y8);
				p_rend = LCNT_W'(y8 + 8'd1);
				p_c0   = x_q;
				p_cend = CCNT_W'(x8 + n_q);
			end
			OP_EL: begin
				p_r0   = LCNT_W'(y8);
				p_rend = LCNT_W'(y8 + 8'd1);
				unique case (cmd_q.mode)
					ERASE_TO_END: begin
						p_c0   = x_q;
						p_cend = geom.width;
					end
					ERASE_TO_START: p_cend = CCNT_W'(x8 + 8'd1);
					ERASE_ALL:      p_cend = geom.width;
					ERASE_NONE:     p_rend = '0;
				endcase
			end
			OP_ED: begin
				unique case (cmd_q.mode)
					ERASE_TO_END: begin
						p_r0     = LCNT_W'(y8);
						p_rend   = LCNT_W'(y8 + 8'd1);
						p_c0     = x_q;
						p_cend   = geom.width;
						p2_valid = 1'b1;
						p2_r0    = LCNT_W'(y8 + 8'd1);
						p2_rend  = geom.height;
						p2_cend  = geom.width;
					end
					ERASE_TO_START: begin
						p_rend   = LCNT_W'(y8);
						p_cend   = geom.width;
						p2_valid = 1'b1;
						p2_r0    = LCNT_W'(y8);
						p2_rend  = LCNT_W'(y8 + 8'd1);
						p2_cend  = CCNT_W'(x8 + 8'd1);
					end
					ERASE_ALL: begin
						p_rend = geom.height;
						p_cend = geom.width;
					end
					ERASE_NONE: p_rend = '0;
				endcase
			end
			OP_SD: begin
				p_org_we = 1'b1;
				p_origin = LINE_W'(sd_t);
				p_rend   = LCNT_W'(n_q);
				p_cend   = geom.width;
			end
			OP_SU: begin
				p_org_we = 1'b1;
				p_origin = LINE_W'(su_t);
				p_r0     = LCNT_W'(h8 - n_q);
				p_rend   = geom.height;
				p_cend   = geom.width;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		mem_req = '0;
		if (cp_s1) begin
			mem_req.we    = 1'b1;
			mem_req.waddr = cp_waddr_s1;
			mem_req.wdata = rdata;
		end
		unique case (state_q)
			ST_INIT: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = init_q;
				mem_req.wdata = '0;
			end
			ST_PLAN: begin
				if (in_page_q && cmd_q.op == OP_WRITE) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = {y_line, x_q};
					mem_req.wdata = CELL_BITS'(cmd_q.value);
				end
				if (in_page_q && cmd_q.op == OP_READ) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = {y_line, x_q};
				end
			end
			ST_COPY: begin
				if (cp_rows_q != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = {s_line, cp_scol_q};
				end
			end
			ST_CLR: begin
				if (cl_active) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = {c_line, cl_col_q};
					mem_req.wdata = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			init_q     <= '0;
			origin_q   <= '0;
			cp_s1      <= 1'b0;
			cp_rows_q  <= '0;
			c2_valid_q <= 1'b0;
			res_q      <= '0;
		end else begin
			// write back the cell read in this cycle
			cp_s1 <= (state_q == ST_COPY) && (cp_rows_q != '0);
			unique case (state_q)
				ST_INIT: begin
					init_q <= init_q + ADDR_W'(1);
					if (init_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cmd_q   <= cmd;
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					// bring the origin below the current ring size
					if ({1'b0, origin_q} >= geom.ring) begin
						origin_q <= LINE_W'({1'b0, origin_q} - geom.ring);
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					x_q <= (cmd_q.col < 8'(geom.width)) ? COL_W'(cmd_q.col)
						: COL_W'(geom.width - CCNT_W'(1));
					y_q <= (LCNT_W'(cmd_q.row) < geom.height) ? cmd_q.row
						: LINE_W'(geom.height - LCNT_W'(1));
					in_page_q <= (LCNT_W'(cmd_q.row) < geom.height)
						&& (cmd_q.col < 8'(geom.width));
					n0_q    <= (cmd_q.cnt == 8'd0) ? 8'd1 : cmd_q.cnt;
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					n_q     <= (n0_q > avail) ? avail : n0_q;
					state_q <= ST_PLAN;
				end
				ST_PLAN: begin
					res_q      <= '0;
					cp_rows_q  <= p_rows;
					cp_ncols_q <= p_ncols;
					cp_left_q  <= p_ncols;
					cp_drow_q  <= p_drow;
					cp_srow_q  <= p_srow;
					cp_dcol_q  <= p_dcol;
					cp_scol_q  <= p_scol;
					cp_dcol0_q <= p_dcol;
					cp_scol0_q <= p_scol;
					cp_down_q  <= p_down;
					cl_row_q   <= p_r0;
					cl_rend_q  <= p_rend;
					cl_col_q   <= p_c0;
					cl_c0_q    <= p_c0;
					cl_cend_q  <= p_cend;
					c2_valid_q <= p2_valid;
					c2_r0_q    <= p2_r0;
					c2_rend_q  <= p2_rend;
					c2_c0_q    <= p2_c0;
					c2_cend_q  <= p2_cend;
					if (p_org_we) begin
						origin_q <= p_origin;
					end
					priority if (cmd_q.op == OP_WRITE) begin
						state_q <= ST_DONE;
					end else if (cmd_q.op == OP_READ) begin
						state_q <= in_page_q ? ST_RWAIT : ST_DONE;
					end else begin
						state_q <= ST_COPY;
					end
				end
				ST_RWAIT: begin
					res_q   <= rdata;
					state_q <= ST_DONE;
				end
				ST_COPY: begin
					if (cp_rows_q != '0) begin
						cp_waddr_s1 <= {d_line, cp_dcol_q};
						if (cp_left_q == CCNT_W'(1)) begin
							// next line pair
							cp_rows_q <= cp_rows_q - LCNT_W'(1);
							cp_left_q <= cp_ncols_q;
							cp_dcol_q <= cp_dcol0_q;
							cp_scol_q <= cp_scol0_q;
							cp_drow_q <= cp_down_q ? cp_drow_q - LINE_W'(1)
								: cp_drow_q + LINE_W'(1);
							cp_srow_q <= cp_down_q ? cp_srow_q - LINE_W'(1)
								: cp_srow_q + LINE_W'(1);
						end else begin
							cp_left_q <= cp_left_q - CCNT_W'(1);
							cp_dcol_q <= cp_down_q ? cp_dcol_q - COL_W'(1)
								: cp_dcol_q + COL_W'(1);
							cp_scol_q <= cp_down_q ? cp_scol_q - COL_W'(1)
								: cp_scol_q + COL_W'(1);
						end
					end else begin
						// last copy write lands in this cycle
						state_q <= ST_CLR;
					end
				end
				ST_CLR: begin
					if (cl_active) begin
						if ({1'b0, cl_col_q} + CCNT_W'(1) == cl_cend_q) begin
							cl_col_q <= cl_c0_q;
							cl_row_q <= cl_row_q + LCNT_W'(1);
						end else begin
							cl_col_q <= cl_col_q + COL_W'(1);
						end
					end else if (c2_valid_q) begin
						c2_valid_q <= 1'b0;
						cl_row_q   <= c2_r0_q;
						cl_rend_q  <= c2_rend_q;
						cl_col_q   <= c2_c0_q;
						cl_c0_q    <= c2_c0_q;
						cl_cend_q  <= c2_cend_q;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/text_screen_edit_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_screen_edit_engine_top
// Character grid kept as a ring of lines, with cell access and screen edits.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the in_valid/in_ready channel; each request gives
//   exactly one result on out_valid/out_ready (read_value, zero unless a read).
//   Geometry registers are written on cfg_valid/cfg_ready (always ready) with
//   cfg_index 0 width, 1 height, 2 ring lines; write them only while idle.
//   After reset a clearing pass zeroes all 8192 cells, one per cycle, while
//   in_ready stays low. One command is worked at a time, every cell access
//   going through the single read and single write port of the store:
//   setup brings the ring origin below the ring size, loads the cursor and
//   saturates the count, then the edit copies cell by cell (all 128 cells of
//   each moved line), clears cell by cell and finishes with the result.
//   The finished result sits in an output register; the next request is
//   taken while it waits, but its own result holds until out_ready frees
//   the register.
// ----------------------------------------------------------------------------
module text_screen_edit_engine_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  operation,
	input  logic [5:0]  cursor_row,
	input  logic [7:0]  cursor_col,
	input  logic [7:0]  repeat_count,
	input  logic [1:0]  erase_mode,
	input  logic [31:0] cell_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] read_value,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tsee_pkg::*;

	logic [7:0] width_q;
	logic [6:0] height_q, ring_q;
	logic       out_valid_q;
	logic [31:0] read_value_q;

	geom_t    geom;
	cmd_t     cmd;
	mem_req_t mem_req;
	logic [CELL_BITS-1:0] rdata, res_value;
	logic     res_valid, res_ready;
	logic [LCNT_W-1:0] h_clamp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 8'd80;
			height_q <= 7'd24;
			ring_q   <= 7'd64;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_WIDTH:  width_q  <= cfg_data;
				CFG_HEIGHT: height_q <= cfg_data[6:0];
				CFG_RING:   ring_q   <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	// saturate the registers to the store geometry
	always_comb begin
		priority if (width_q == 8'd0) begin
			geom.width = CCNT_W'(1);
		end else if (width_q > 8'(MAX_COLS)) begin
			geom.width = CCNT_W'(MAX_COLS);
		end else begin
			geom.width = CCNT_W'(width_q);
		end
		priority if (ring_q == 7'd0) begin
			geom.ring = LCNT_W'(1);
		end else if (ring_q > 7'(MAX_LINES)) begin
			geom.ring = LCNT_W'(MAX_LINES);
		end else begin
			geom.ring = LCNT_W'(ring_q);
		end
		priority if (height_q == 7'd0) begin
			h_clamp = LCNT_W'(1);
		end else if (height_q > 7'(MAX_LINES)) begin
			h_clamp = LCNT_W'(MAX_LINES);
		end else begin
			h_clamp = LCNT_W'(height_q);
		end
		geom.height = (h_clamp < geom.ring) ? h_clamp : geom.ring;
	end

	assign cmd.op    = operation;
	assign cmd.row   = cursor_row;
	assign cmd.col   = cursor_col;
	assign cmd.cnt   = repeat_count;
	assign cmd.mode  = erase_mode;
	assign cmd.value = cell_value;

	tsee_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.cmd_valid (in_valid),
		.cmd_ready (in_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_value (res_value),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	tsee_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			read_value_q <= 32'(res_value);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;

endmodule
